### hdl/scr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_pkg
// Shared widths, register codes, control word format and the microcode
// program of the skin conductance response counter.
// ----------------------------------------------------------------------------
package scr_pkg;

    // Sample and fixed-point formats.
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int TONIC_FRAC      = 20;
    localparam int Q8_W            = 28;
    localparam int PHASIC_W        = 29;
    localparam int COUNT_W         = 8;
    localparam int TS_W            = 32;

    // Conductance scale 1000 uS times 256, and the ratios of the range tests.
    localparam int COND_SCALE = 256000;
    localparam int SCALE_W    = 18;
    localparam int LOW_RATIO  = 330;
    localparam int NEAR_NUM   = 1001;
    localparam int NEAR_DEN   = 1000;

    // Configuration register widths.
    localparam int BASE_W     = 16;
    localparam int DELTA_W    = 12;
    localparam int THR_W      = 24;
    localparam int WIN_W      = 32;
    localparam int ALPHA_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration reset values.
    localparam logic [BASE_W-1:0]  BASELINE_RST  = 16'd0;
    localparam logic [DELTA_W-1:0] DELTA_RST     = 12'd500;
    localparam logic [THR_W-1:0]   THRESHOLD_RST = 24'd7680;
    localparam logic [WIN_W-1:0]   WINDOW_RST    = 32'd60000;
    localparam logic [ALPHA_W-1:0] ALPHA_RST     = 16'd131;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASELINE    = 3'd0,
        REG_SPIKE_DELTA = 3'd1,
        REG_THRESHOLD   = 3'd2,
        REG_WINDOW      = 3'd3,
        REG_ALPHA       = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [BASE_W-1:0]  baseline_q4;
        logic [DELTA_W-1:0] spike_delta;
        logic [THR_W-1:0]   scr_threshold_q8;
        logic [WIN_W-1:0]   window_ms;
        logic [ALPHA_W-1:0] tonic_alpha_q16;
    } cfg_t;

    // Datapath operations, one per control word.
    typedef enum logic [3:0] {
        OP_ACCEPT,
        OP_TONIC_MUL,
        OP_TONIC_ADD,
        OP_RAW_LOAD,
        OP_TONIC_LOAD,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_RAW_STORE,
        OP_TONIC_STORE,
        OP_UPDATE,
        OP_EMIT,
        OP_NOP
    } op_t;

    // Jump conditions of the sequencer.
    typedef enum logic [2:0] {
        J_NONE,
        J_ALWAYS,
        J_NO_INPUT,
        J_LOW_SAMPLE,
        J_DIV_BUSY,
        J_OUT_BUSY
    } jump_t;

    localparam int PC_W = 4;

    typedef struct packed {
        op_t             op;
        jump_t           jump;
        logic [PC_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic no_input;
        logic low_sample;
        logic div_busy;
        logic out_busy;
    } status_t;

    // Program addresses.
    localparam logic [PC_W-1:0] PC_ACCEPT      = 4'd0;
    localparam logic [PC_W-1:0] PC_TONIC_MUL   = 4'd1;
    localparam logic [PC_W-1:0] PC_TONIC_ADD   = 4'd2;
    localparam logic [PC_W-1:0] PC_RAW_LOAD    = 4'd3;
    localparam logic [PC_W-1:0] PC_RAW_INIT    = 4'd4;
    localparam logic [PC_W-1:0] PC_RAW_DIV     = 4'd5;
    localparam logic [PC_W-1:0] PC_RAW_STORE   = 4'd6;
    localparam logic [PC_W-1:0] PC_TONIC_LOAD  = 4'd7;
    localparam logic [PC_W-1:0] PC_TONIC_INIT  = 4'd8;
    localparam logic [PC_W-1:0] PC_TONIC_DIV   = 4'd9;
    localparam logic [PC_W-1:0] PC_TONIC_STORE = 4'd10;
    localparam logic [PC_W-1:0] PC_UPDATE      = 4'd11;
    localparam logic [PC_W-1:0] PC_EMIT        = 4'd12;
    localparam logic [PC_W-1:0] PC_RETURN      = 4'd13;

    // Control store: one control word per program step.
    function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_t w;
        unique case (pc)
            PC_ACCEPT:      w = '{op: OP_ACCEPT,      jump: J_NO_INPUT,   target: PC_ACCEPT};
            PC_TONIC_MUL:   w = '{op: OP_TONIC_MUL,   jump: J_NONE,       target: PC_ACCEPT};
            PC_TONIC_ADD:   w = '{op: OP_TONIC_ADD,   jump: J_LOW_SAMPLE, target: PC_UPDATE};
            PC_RAW_LOAD:    w = '{op: OP_RAW_LOAD,    jump: J_NONE,       target: PC_ACCEPT};
            PC_RAW_INIT:    w = '{op: OP_DIV_INIT,    jump: J_NONE,       target: PC_ACCEPT};
            PC_RAW_DIV:     w = '{op: OP_DIV_STEP,    jump: J_DIV_BUSY,   target: PC_RAW_DIV};
            PC_RAW_STORE:   w = '{op: OP_RAW_STORE,   jump: J_NONE,       target: PC_ACCEPT};
            PC_TONIC_LOAD:  w = '{op: OP_TONIC_LOAD,  jump: J_NONE,       target: PC_ACCEPT};
            PC_TONIC_INIT:  w = '{op: OP_DIV_INIT,    jump: J_NONE,       target: PC_ACCEPT};
            PC_TONIC_DIV:   w = '{op: OP_DIV_STEP,    jump: J_DIV_BUSY,   target: PC_TONIC_DIV};
            PC_TONIC_STORE: w = '{op: OP_TONIC_STORE, jump: J_NONE,       target: PC_ACCEPT};
            PC_UPDATE:      w = '{op: OP_UPDATE,      jump: J_NONE,       target: PC_ACCEPT};
            PC_EMIT:        w = '{op: OP_EMIT,        jump: J_OUT_BUSY,   target: PC_EMIT};
            PC_RETURN:      w = '{op: OP_NOP,         jump: J_ALWAYS,     target: PC_ACCEPT};
            default:        w = '{op: OP_NOP,         jump: J_ALWAYS,     target: PC_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

### hdl/scr_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_divider
// Restoring divider that produces one quotient bit per step, with the
// quotient saturated to all ones when it would not fit.
// ----------------------------------------------------------------------------
module scr_divider import scr_pkg::*; #(
    parameter int DEN_W = 32,
    parameter int NUM_W = 50,
    parameter int QUO_W = Q8_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic             step,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quotient,
    output logic             busy
);

    localparam int CNT_W = $clog2(QUO_W);
    localparam int CMP_W = DEN_W + QUO_W;

    logic [DEN_W-1:0] rem_reg;
    logic [QUO_W-1:0] quo_reg;
    logic             ovf_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W:0]   trial;
    logic             fits;
    logic             ovf;

    // The quotient fits only when the numerator is below den shifted by the
    // quotient width; the upper numerator bits then start as the remainder.
    assign ovf   = CMP_W'(num) >= {den, {QUO_W{1'b0}}};
    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign fits  = trial >= {1'b0, den};

    // Step counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CNT_W'(QUO_W - 1);
        end else if (step && cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Remainder and quotient shift register.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DEN_W'(num[NUM_W-1:QUO_W]);
            quo_reg <= num[QUO_W-1:0];
            ovf_reg <= ovf;
        end else if (step) begin
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
        end
    end

    assign quotient = ovf_reg ? {QUO_W{1'b1}} : quo_reg;
    assign busy     = cnt_reg != '0;

endmodule

### hdl/scr_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_sequencer
// Step counter over the microcode store, with conditional jumps taken from
// the datapath status.
// ----------------------------------------------------------------------------
module scr_sequencer import scr_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  status_t status,
    output ctrl_t   ctrl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            take_jump;

    // Current control word.
    assign ctrl = ucode_rom(pc_reg);

    // Jump condition selected by the control word.
    always_comb begin
        unique case (ctrl.jump)
            J_NONE:       take_jump = 1'b0;
            J_ALWAYS:     take_jump = 1'b1;
            J_NO_INPUT:   take_jump = status.no_input;
            J_LOW_SAMPLE: take_jump = status.low_sample;
            J_DIV_BUSY:   take_jump = status.div_busy;
            J_OUT_BUSY:   take_jump = status.out_busy;
            default:      take_jump = 1'b0;
        endcase
    end

    assign pc_next = take_jump ? ctrl.target : pc_reg + 1'b1;

    // Step counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_ACCEPT;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

### hdl/scr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_datapath
// Tonic average, conductance setup, response counting and the result
// register, each step driven by the current control word.
// ----------------------------------------------------------------------------
module scr_datapath import scr_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  ctrl_t                      ctrl,
    input  cfg_t                       cfg,
    output status_t                    status,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [SAMPLE_BITS-1:0]     s_raw_sample,
    input  logic [TS_W-1:0]            s_timestamp_ms,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [Q8_W-1:0]            m_conductance_q8,
    output logic [Q8_W-1:0]            m_tonic_q8,
    output logic signed [PHASIC_W-1:0] m_phasic_q8,
    output logic [COUNT_W-1:0]         m_responses_per_window,
    output logic                       m_window_closed,
    output logic                       m_stress_spike
);

    localparam int SW  = SAMPLE_BITS;
    localparam int TW  = SW + TONIC_FRAC;
    localparam int NW  = TW + SCALE_W;
    localparam int PW  = TW + ALPHA_W + 2;
    localparam int SPW = (SW + 4 > BASE_W + 1) ? SW + 5 : BASE_W + 2;
    localparam logic [SW-1:0]    FS        = {SW{1'b1}};
    localparam logic [TW-1:0]    FST       = {FS, {TONIC_FRAC{1'b0}}};
    localparam logic [SW+9:0]    FS_X1000  = (SW+10)'(FS) * (SW+10)'(NEAR_DEN);
    localparam logic [TW+9:0]    FST_X1000 = (TW+10)'(FST) * (TW+10)'(NEAR_DEN);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Sample and arithmetic registers.
    logic [SW-1:0]          raw_reg;
    logic [TS_W-1:0]        ts_reg;
    logic signed [PW-1:0]   prod_reg;
    logic [NW-1:0]          num_reg;
    logic [TW-1:0]          den_reg;
    logic                   zero_reg;

    // Block state.
    logic                   seeded_reg;
    logic [TW-1:0]          tonic_reg;
    logic [Q8_W-1:0]        cond_reg;
    logic [Q8_W-1:0]        tonic_q8_reg;
    logic [PHASIC_W-1:0]    phasic_reg;
    logic                   was_above_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic [TS_W-1:0]        window_start_reg;
    logic [COUNT_W-1:0]     latched_reg;
    logic                   closed_reg;
    logic                   spike_reg;

    // Result register.
    logic                   m_valid_reg;
    logic [Q8_W-1:0]        m_cond_reg;
    logic [Q8_W-1:0]        m_tonic_reg;
    logic [PHASIC_W-1:0]    m_phasic_reg;
    logic [COUNT_W-1:0]     m_rate_reg;
    logic                   m_closed_reg;
    logic                   m_spike_reg;

    // Combinational terms.
    logic [TW-1:0]          raw_shift;
    logic signed [TW:0]     diff;
    logic signed [PW-1:0]   prod_next;
    logic signed [PW-1:0]   tonic_step;
    logic [TW-1:0]          tonic_next;
    logic [SW+8:0]          raw_x330;
    logic [SW+9:0]          raw_x1001;
    logic [TW+8:0]          t_x330;
    logic [TW+9:0]          t_x1001;
    logic                   low_sample;
    logic                   raw_near;
    logic                   tonic_zero;
    logic [Q8_W-1:0]        div_quot;
    logic                   div_busy;
    logic [Q8_W-1:0]        div_result;
    logic                   above;
    logic [COUNT_W-1:0]     count_next;
    logic [TS_W-1:0]        elapsed;
    logic                   window_done;
    logic                   spike;
    logic                   out_free;
    logic                   accept;

    // Tonic update: difference to the shifted sample times alpha, then an
    // arithmetic shift, which floors in both directions.
    assign raw_shift  = {raw_reg, {TONIC_FRAC{1'b0}}};
    assign diff       = $signed({1'b0, raw_shift}) - $signed({1'b0, tonic_reg});
    assign prod_next  = diff * $signed({1'b0, cfg.tonic_alpha_q16});
    assign tonic_step = prod_reg >>> ALPHA_W;
    assign tonic_next = tonic_reg + tonic_step[TW-1:0];

    // Range tests on the sample and on the tonic level.
    assign raw_x330   = (SW+9)'(raw_reg) * (SW+9)'(LOW_RATIO);
    assign raw_x1001  = (SW+10)'(raw_reg) * (SW+10)'(NEAR_NUM);
    assign t_x330     = (TW+9)'(tonic_reg) * (TW+9)'(LOW_RATIO);
    assign t_x1001    = (TW+10)'(tonic_reg) * (TW+10)'(NEAR_NUM);
    assign low_sample = raw_x330 <= (SW+9)'(FS);
    assign raw_near   = raw_x1001 >= FS_X1000;
    assign tonic_zero = (t_x330 <= (TW+9)'(FST)) || (t_x1001 >= FST_X1000);

    // Shared divider for both conductances.
    scr_divider #(
        .DEN_W (TW),
        .NUM_W (NW),
        .QUO_W (Q8_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctrl.op == OP_DIV_INIT),
        .step     (ctrl.op == OP_DIV_STEP),
        .num      (num_reg),
        .den      (den_reg),
        .quotient (div_quot),
        .busy     (div_busy)
    );

    assign div_result = zero_reg ? '0 : div_quot;

    // Rising crossing count, window test and spike test.
    assign above = $signed(phasic_reg)
                 > $signed({{(PHASIC_W-THR_W){1'b0}}, cfg.scr_threshold_q8});
    assign count_next = (above && !was_above_reg && count_reg != COUNT_MAX)
                      ? count_reg + 1'b1 : count_reg;
    assign elapsed     = ts_reg - window_start_reg;
    assign window_done = elapsed >= cfg.window_ms;
    assign spike = SPW'({raw_reg, 4'b0000})
                 > SPW'(cfg.baseline_q4) + SPW'({cfg.spike_delta, 4'b0000});

    // Handshakes and status for the sequencer.
    assign s_ready  = ctrl.op == OP_ACCEPT;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign status.no_input   = !s_valid;
    assign status.low_sample = low_sample;
    assign status.div_busy   = div_busy;
    assign status.out_busy   = !out_free;

    // Working registers that need no reset.
    always_ff @(posedge aclk) begin
        unique case (ctrl.op)
            OP_ACCEPT: begin
                if (accept) begin
                    raw_reg <= s_raw_sample;
                    ts_reg  <= s_timestamp_ms;
                end
            end
            OP_TONIC_MUL: begin
                // A first sample seeds the level, so its step is zero.
                prod_reg <= seeded_reg ? prod_next : '0;
            end
            OP_RAW_LOAD: begin
                num_reg  <= NW'(raw_reg) * NW'(COND_SCALE);
                den_reg  <= TW'(FS) - TW'(raw_reg);
                zero_reg <= raw_near;
            end
            OP_TONIC_LOAD: begin
                num_reg  <= NW'(tonic_reg) * NW'(COND_SCALE);
                den_reg  <= FST - tonic_reg;
                zero_reg <= tonic_zero;
            end
            default: begin
            end
        endcase
    end

    // Tonic, held conductances, counting and window state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seeded_reg       <= 1'b0;
            tonic_reg        <= '0;
            cond_reg         <= '0;
            tonic_q8_reg     <= '0;
            phasic_reg       <= '0;
            was_above_reg    <= 1'b0;
            count_reg        <= '0;
            window_start_reg <= '0;
            latched_reg      <= '0;
            closed_reg       <= 1'b0;
            spike_reg        <= 1'b0;
        end else begin
            unique case (ctrl.op)
                OP_TONIC_MUL: begin
                    if (!seeded_reg) begin
                        seeded_reg       <= 1'b1;
                        tonic_reg        <= raw_shift;
                        window_start_reg <= ts_reg;
                    end
                end
                OP_TONIC_ADD: begin
                    tonic_reg <= tonic_next;
                end
                OP_RAW_STORE: begin
                    cond_reg <= div_result;
                end
                OP_TONIC_STORE: begin
                    tonic_q8_reg <= div_result;
                    phasic_reg   <= {1'b0, cond_reg} - {1'b0, div_result};
                end
                OP_UPDATE: begin
                    was_above_reg <= above;
                    closed_reg    <= window_done;
                    spike_reg     <= spike;
                    if (window_done) begin
                        latched_reg      <= count_next;
                        count_reg        <= '0;
                        window_start_reg <= ts_reg;
                    end else begin
                        count_reg <= count_next;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result valid flag: set on the emit step, cleared when the
    // transaction completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.op == OP_EMIT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (ctrl.op == OP_EMIT && out_free) begin
            m_cond_reg   <= cond_reg;
            m_tonic_reg  <= tonic_q8_reg;
            m_phasic_reg <= phasic_reg;
            m_rate_reg   <= latched_reg;
            m_closed_reg <= closed_reg;
            m_spike_reg  <= spike_reg;
        end
    end

    assign m_valid                = m_valid_reg;
    assign m_conductance_q8       = m_cond_reg;
    assign m_tonic_q8             = m_tonic_reg;
    assign m_phasic_q8            = $signed(m_phasic_reg);
    assign m_responses_per_window = m_rate_reg;
    assign m_window_closed        = m_closed_reg;
    assign m_stress_spike         = m_spike_reg;

endmodule

### hdl/skin_conductance_scr_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skin_conductance_scr_counter
// Each accepted sample runs the microcode program: tonic update, then the two
// 28-step conductance divisions on the one shared divider, skipped for a
// sample in the low range whose conductances are held, then the response
// update and the emit step. A new sample is taken only after its emit step.
// A finished result waits in the output register while the next sample is
// taken. Reset (aresetn, synchronous, active low) restores the register
// defaults and clears the tonic, count and window state at once.
// ----------------------------------------------------------------------------
module skin_conductance_scr_counter import scr_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [SAMPLE_BITS-1:0]     s_raw_sample,
    input  logic [TS_W-1:0]            s_timestamp_ms,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [Q8_W-1:0]            m_conductance_q8,
    output logic [Q8_W-1:0]            m_tonic_q8,
    output logic signed [PHASIC_W-1:0] m_phasic_q8,
    output logic [COUNT_W-1:0]         m_responses_per_window,
    output logic                       m_window_closed,
    output logic                       m_stress_spike,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    cfg_t    cfg_reg;
    ctrl_t   ctrl;
    status_t status;

    // Configuration writes are taken on every cycle.
    assign cfg_ready = 1'b1;

    // Configuration registers; writes beyond the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.baseline_q4      <= BASELINE_RST;
            cfg_reg.spike_delta      <= DELTA_RST;
            cfg_reg.scr_threshold_q8 <= THRESHOLD_RST;
            cfg_reg.window_ms        <= WINDOW_RST;
            cfg_reg.tonic_alpha_q16  <= ALPHA_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_BASELINE:    cfg_reg.baseline_q4      <= cfg_data[BASE_W-1:0];
                REG_SPIKE_DELTA: cfg_reg.spike_delta      <= cfg_data[DELTA_W-1:0];
                REG_THRESHOLD:   cfg_reg.scr_threshold_q8 <= cfg_data[THR_W-1:0];
                REG_WINDOW:      cfg_reg.window_ms        <= cfg_data[WIN_W-1:0];
                REG_ALPHA:       cfg_reg.tonic_alpha_q16  <= cfg_data[ALPHA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Microcode sequencer.
    scr_sequencer u_sequencer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    // Datapath with the shared divider and the result register.
    scr_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .ctrl                   (ctrl),
        .cfg                    (cfg_reg),
        .status                 (status),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_raw_sample           (s_raw_sample),
        .s_timestamp_ms         (s_timestamp_ms),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_conductance_q8       (m_conductance_q8),
        .m_tonic_q8             (m_tonic_q8),
        .m_phasic_q8            (m_phasic_q8),
        .m_responses_per_window (m_responses_per_window),
        .m_window_closed        (m_window_closed),
        .m_stress_spike         (m_stress_spike)
    );

    // An accepted transaction moves the sequencer off the accept step.
    a_accept_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("sequencer stayed on the accept step after a transaction");

    // The division loop ends when the divider reports its last step.
    a_div_loop_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_DIV_STEP && !status.div_busy) |=> ctrl.op != OP_DIV_STEP)
        else $error("division loop ran past its last step");

    // The emit step waits while the previous result is still pending.
    a_emit_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_EMIT && status.out_busy) |=> ctrl.op == OP_EMIT)
        else $error("emit step left while the output register was full");

    // A result appears only through the emit step.
    a_valid_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(ctrl.op == OP_EMIT))
        else $error("result valid raised outside the emit step");

endmodule
